### rtl/core/kabf_pkg.sv
// kabf_pkg: shared types, codes and helpers for the angle/bias kalman filter
// sequencer states, datapath control struct, register indexes, saturation
// no dependencies
`timescale 1ns / 1ps

package kabf_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_ANGLE_NOISE = 31'd16777;
    localparam logic [CFG_DATA_W-1:0] RST_BIAS_NOISE  = 31'd50332;
    localparam logic [CFG_DATA_W-1:0] RST_MEAS_NOISE  = 31'd503316;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [67:0] SAT_HI  = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO  = -68'sd2147483648;

    // rounding offsets for the two fixed point shifts
    localparam logic signed [66:0] RND_16 = 67'sd32768;
    localparam logic signed [66:0] RND_24 = 67'sd8388608;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_MUL_RATE,
        ST_ACC_ANG,
        ST_MUL_T,
        ST_ACC_T,
        ST_INNER,
        ST_MUL_P00,
        ST_ACC_P00,
        ST_SUB_P01,
        ST_SUB_P10,
        ST_MUL_P11,
        ST_ACC_P11,
        ST_SUM_S,
        ST_INNOV,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_MUL_K0A,
        ST_ACC_K0A,
        ST_MUL_K1A,
        ST_ACC_K1A,
        ST_MUL_C10,
        ST_ACC_C10,
        ST_MUL_C00,
        ST_ACC_C00,
        ST_MUL_C11,
        ST_ACC_C11,
        ST_MUL_C01,
        ST_ACC_C01,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MA_TMP,
        MA_P11,
        MA_BPN,
        MA_K0,
        MA_K1
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_DT,
        MB_INNOV,
        MB_P00,
        MB_P01
    } t_mul_b;

    typedef enum logic [2:0] {
        AD_NONE,
        AD_ANG,
        AD_BIAS,
        AD_P00,
        AD_P01,
        AD_P10,
        AD_P11,
        AD_INNOV
    } t_acc_dst;

    typedef enum logic [1:0] {
        AT_PROD,
        AT_T,
        AT_ANG
    } t_acc_term;

    typedef enum logic [1:0] {
        TO_NONE,
        TO_RATE,
        TO_INNER
    } t_tmp_op;

    typedef struct packed {
        logic      mul_en;
        t_mul_a    mul_a_sel;
        t_mul_b    mul_b_sel;
        logic      rnd24;
        t_acc_dst  acc_dst;
        t_acc_term acc_term;
        logic      acc_neg;
        t_tmp_op   tmp_op;
        logic      ld_t;
        logic      ld_s;
        logic      div_init;
        logic      div_step;
        logic      div_done;
    } t_ctrl;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > SAT_HI) return S32_MAX;
        if (x < SAT_LO) return S32_MIN;
        return 32'(x);
    endfunction

endpackage

### rtl/core/kalman_angle_bias_filter_unit.sv
// kalman_angle_bias_filter_unit: two-state angle/gyro-bias kalman filter
// one shared multiplier, one saturating adder and a bit-serial divider
// under a sequencer; depends on kabf_pkg
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+--------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | measured_angle, measured_rate, time_step
//  m_axis    | out | m_axis_tvalid/tready    | filtered_angle, estimated_bias
//  cfg       | in  | i_cfg_we                | i_cfg_idx, i_cfg_wdata (noise registers)
//
// one transaction runs from accept to the next possible accept under the
// sequencer, which takes no new input until it is back in idle: ten multiply/accumulate
// passes through the one multiplier and two gains from the 1 bit per cycle divider
// reset (synchronous, active low) clears the estimates, covariance and loads the
// default noise values; a result waits in the output register, and the
// sequencer only holds in its last step when that register is still full
`timescale 1ns / 1ps

module kalman_angle_bias_filter_unit
    import kabf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] measured_angle, [63:32] measured_rate, [79:64] time_step
    input  logic [79:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] filtered_angle, [63:32] estimated_bias
    output logic [63:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    // configuration
    logic [CFG_DATA_W-1:0] r_apn, r_bpn, r_mn;

    // filter state
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;

    // latched input
    logic signed [31:0] r_meas, r_rate_in;
    logic [15:0]        r_dt;

    // working registers
    logic signed [66:0] r_prod;
    logic signed [34:0] r_tmp;
    logic signed [33:0] r_t;
    logic signed [32:0] r_s;
    logic signed [31:0] r_innov, r_k0, r_k1;

    // divider
    logic        r_dsel, r_div_neg, r_div_zero, r_div_ovf;
    logic [31:0] r_rem, r_dlo, r_quo, r_dvs;
    logic [4:0]  r_dcnt;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_ang, r_out_bias;

    logic in_accept, out_free;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_bias, r_out_ang};

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (in_accept) n_state = ST_RATE;
            ST_RATE:     n_state = ST_MUL_RATE;
            ST_MUL_RATE: n_state = ST_ACC_ANG;
            ST_ACC_ANG:  n_state = ST_MUL_T;
            ST_MUL_T:    n_state = ST_ACC_T;
            ST_ACC_T:    n_state = ST_INNER;
            ST_INNER:    n_state = ST_MUL_P00;
            ST_MUL_P00:  n_state = ST_ACC_P00;
            ST_ACC_P00:  n_state = ST_SUB_P01;
            ST_SUB_P01:  n_state = ST_SUB_P10;
            ST_SUB_P10:  n_state = ST_MUL_P11;
            ST_MUL_P11:  n_state = ST_ACC_P11;
            ST_ACC_P11:  n_state = ST_SUM_S;
            ST_SUM_S:    n_state = ST_INNOV;
            ST_INNOV:    n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = ST_DIV_RUN;
            ST_DIV_RUN:  if (r_dcnt == 5'd31) n_state = ST_DIV_DONE;
            ST_DIV_DONE: n_state = r_dsel ? ST_MUL_K0A : ST_DIV_INIT;
            ST_MUL_K0A:  n_state = ST_ACC_K0A;
            ST_ACC_K0A:  n_state = ST_MUL_K1A;
            ST_MUL_K1A:  n_state = ST_ACC_K1A;
            ST_ACC_K1A:  n_state = ST_MUL_C10;
            ST_MUL_C10:  n_state = ST_ACC_C10;
            ST_ACC_C10:  n_state = ST_MUL_C00;
            ST_MUL_C00:  n_state = ST_ACC_C00;
            ST_ACC_C00:  n_state = ST_MUL_C11;
            ST_MUL_C11:  n_state = ST_ACC_C11;
            ST_ACC_C11:  n_state = ST_MUL_C01;
            ST_MUL_C01:  n_state = ST_ACC_C01;
            ST_ACC_C01:  n_state = ST_OUT;
            ST_OUT:      if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '{mul_en: 1'b0, mul_a_sel: MA_TMP, mul_b_sel: MB_DT, rnd24: 1'b0,
                 acc_dst: AD_NONE, acc_term: AT_PROD, acc_neg: 1'b0, tmp_op: TO_NONE,
                 ld_t: 1'b0, ld_s: 1'b0, div_init: 1'b0, div_step: 1'b0,
                 div_done: 1'b0};
        case (r_state)
            ST_RATE:     ctrl.tmp_op = TO_RATE;
            ST_MUL_RATE: ctrl.mul_en = 1'b1;
            ST_ACC_ANG:  ctrl.acc_dst = AD_ANG;
            ST_MUL_T: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_P11;
            end
            ST_ACC_T:    ctrl.ld_t = 1'b1;
            ST_INNER:    ctrl.tmp_op = TO_INNER;
            ST_MUL_P00:  ctrl.mul_en = 1'b1;
            ST_ACC_P00:  ctrl.acc_dst = AD_P00;
            ST_SUB_P01: begin
                ctrl.acc_dst  = AD_P01;
                ctrl.acc_term = AT_T;
                ctrl.acc_neg  = 1'b1;
            end
            ST_SUB_P10: begin
                ctrl.acc_dst  = AD_P10;
                ctrl.acc_term = AT_T;
                ctrl.acc_neg  = 1'b1;
            end
            ST_MUL_P11: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_BPN;
            end
            ST_ACC_P11:  ctrl.acc_dst = AD_P11;
            ST_SUM_S:    ctrl.ld_s = 1'b1;
            ST_INNOV: begin
                ctrl.acc_dst  = AD_INNOV;
                ctrl.acc_term = AT_ANG;
                ctrl.acc_neg  = 1'b1;
            end
            ST_DIV_INIT: ctrl.div_init = 1'b1;
            ST_DIV_RUN:  ctrl.div_step = 1'b1;
            ST_DIV_DONE: ctrl.div_done = 1'b1;
            ST_MUL_K0A: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_K0;
                ctrl.mul_b_sel = MB_INNOV;
            end
            ST_ACC_K0A: begin
                ctrl.acc_dst = AD_ANG;
                ctrl.rnd24   = 1'b1;
            end
            ST_MUL_K1A: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_K1;
                ctrl.mul_b_sel = MB_INNOV;
            end
            ST_ACC_K1A: begin
                ctrl.acc_dst = AD_BIAS;
                ctrl.rnd24   = 1'b1;
            end
            // covariance order keeps old p00 and p01 until their last use
            ST_MUL_C10: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_K1;
                ctrl.mul_b_sel = MB_P00;
            end
            ST_ACC_C10: begin
                ctrl.acc_dst = AD_P10;
                ctrl.rnd24   = 1'b1;
                ctrl.acc_neg = 1'b1;
            end
            ST_MUL_C00: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_K0;
                ctrl.mul_b_sel = MB_P00;
            end
            ST_ACC_C00: begin
                ctrl.acc_dst = AD_P00;
                ctrl.rnd24   = 1'b1;
                ctrl.acc_neg = 1'b1;
            end
            ST_MUL_C11: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_K1;
                ctrl.mul_b_sel = MB_P01;
            end
            ST_ACC_C11: begin
                ctrl.acc_dst = AD_P11;
                ctrl.rnd24   = 1'b1;
                ctrl.acc_neg = 1'b1;
            end
            ST_MUL_C01: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_a_sel = MA_K0;
                ctrl.mul_b_sel = MB_P01;
            end
            ST_ACC_C01: begin
                ctrl.acc_dst = AD_P01;
                ctrl.rnd24   = 1'b1;
                ctrl.acc_neg = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------ datapath
    logic signed [34:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [66:0] mul_res, rnd_sum, term_prod, term, base;
    logic signed [67:0] acc_sum;
    logic signed [31:0] acc_sat;

    always_comb begin
        case (ctrl.mul_a_sel)
            MA_TMP:  mul_a = r_tmp;
            MA_P11:  mul_a = 35'(r_p11);
            MA_BPN:  mul_a = $signed({4'b0, r_bpn});
            MA_K0:   mul_a = 35'(r_k0);
            MA_K1:   mul_a = 35'(r_k1);
            default: mul_a = r_tmp;
        endcase
        case (ctrl.mul_b_sel)
            MB_DT:    mul_b = $signed({16'b0, r_dt});
            MB_INNOV: mul_b = r_innov;
            MB_P00:   mul_b = r_p00;
            MB_P01:   mul_b = r_p01;
            default:  mul_b = $signed({16'b0, r_dt});
        endcase
    end

    assign mul_res   = 67'(mul_a) * 67'(mul_b);
    // round half up, then arithmetic shift back to the target format
    assign rnd_sum   = r_prod + (ctrl.rnd24 ? RND_24 : RND_16);
    assign term_prod = ctrl.rnd24 ? (rnd_sum >>> 24) : (rnd_sum >>> 16);

    always_comb begin
        case (ctrl.acc_term)
            AT_PROD: term = term_prod;
            AT_T:    term = 67'(r_t);
            AT_ANG:  term = 67'(r_ang);
            default: term = term_prod;
        endcase
        case (ctrl.acc_dst)
            AD_ANG:   base = 67'(r_ang);
            AD_BIAS:  base = 67'(r_bias);
            AD_P00:   base = 67'(r_p00);
            AD_P01:   base = 67'(r_p01);
            AD_P10:   base = 67'(r_p10);
            AD_P11:   base = 67'(r_p11);
            AD_INNOV: base = 67'(r_meas);
            default:  base = '0;
        endcase
    end

    assign acc_sum = 68'(base) + (ctrl.acc_neg ? -68'(term) : 68'(term));
    assign acc_sat = sat32(acc_sum);

    // divider setup: magnitudes of numerator (p * 2^24) and divisor
    logic signed [31:0] num_p;
    logic [32:0]        neg_p, neg_s;
    logic [31:0]        abs_p, abs_s;
    logic [32:0]        trial, diff;
    logic               trial_ge;
    logic signed [31:0] gain;
    logic [31:0]        neg_quo;

    assign num_p = r_dsel ? r_p10 : r_p00;
    assign neg_p = 33'd0 - {num_p[31], num_p};
    assign neg_s = 33'd0 - r_s;
    assign abs_p = num_p[31] ? neg_p[31:0] : num_p;
    assign abs_s = r_s[32] ? neg_s[31:0] : r_s[31:0];

    assign trial    = {r_rem, r_dlo[31]};
    assign diff     = trial - {1'b0, r_dvs};
    assign trial_ge = (trial >= {1'b0, r_dvs});
    assign neg_quo  = 32'd0 - r_quo;

    always_comb begin
        if (r_div_zero) begin
            gain = '0;
        end else if (r_div_ovf) begin
            gain = r_div_neg ? S32_MIN : S32_MAX;
        end else if (r_div_neg) begin
            gain = (r_quo > 32'h8000_0000) ? S32_MIN : $signed(neg_quo);
        end else begin
            gain = r_quo[31] ? S32_MAX : $signed(r_quo);
        end
    end

    // ------------------------------------------------------------ control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_apn       <= RST_ANGLE_NOISE;
            r_bpn       <= RST_BIAS_NOISE;
            r_mn        <= RST_MEAS_NOISE;
            r_ang       <= '0;
            r_bias      <= '0;
            r_p00       <= '0;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= '0;
            r_dsel      <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ANGLE_NOISE: r_apn <= i_cfg_wdata;
                    REG_BIAS_NOISE:  r_bpn <= i_cfg_wdata;
                    REG_MEAS_NOISE:  r_mn  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (ctrl.acc_dst)
                AD_ANG:  r_ang  <= acc_sat;
                AD_BIAS: r_bias <= acc_sat;
                AD_P00:  r_p00  <= acc_sat;
                AD_P01:  r_p01  <= acc_sat;
                AD_P10:  r_p10  <= acc_sat;
                AD_P11:  r_p11  <= acc_sat;
                default: ;
            endcase
            if (ctrl.div_init) r_dcnt <= '0;
            if (ctrl.div_step) r_dcnt <= r_dcnt + 5'd1;
            if (ctrl.div_done) r_dsel <= ~r_dsel;
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_meas    <= s_axis_tdata[31:0];
            r_rate_in <= s_axis_tdata[63:32];
            r_dt      <= s_axis_tdata[79:64];
        end
        if (ctrl.mul_en) r_prod <= mul_res;
        case (ctrl.tmp_op)
            TO_RATE:  r_tmp <= 35'(r_rate_in) - 35'(r_bias);
            TO_INNER: r_tmp <= 35'(r_t) - 35'(r_p01) - 35'(r_p10) + $signed({4'b0, r_apn});
            default: ;
        endcase
        if (ctrl.ld_t) r_t <= 34'(term_prod);
        if (ctrl.ld_s) r_s <= 33'(r_p00) + $signed({2'b0, r_mn});
        if (ctrl.acc_dst == AD_INNOV) r_innov <= acc_sat;
        if (ctrl.div_init) begin
            r_div_neg  <= num_p[31] ^ r_s[32];
            r_div_zero <= (r_s == '0);
            r_div_ovf  <= ({8'b0, abs_p[31:8]} >= abs_s);
            r_rem      <= {8'b0, abs_p[31:8]};
            r_dlo      <= {abs_p[7:0], 24'b0};
            r_quo      <= '0;
            r_dvs      <= abs_s;
        end
        if (ctrl.div_step) begin
            r_rem <= trial_ge ? diff[31:0] : trial[31:0];
            r_dlo <= {r_dlo[30:0], 1'b0};
            r_quo <= {r_quo[30:0], trial_ge};
        end
        if (ctrl.div_done) begin
            if (r_dsel) r_k1 <= gain;
            else        r_k0 <= gain;
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_ang  <= r_ang;
            r_out_bias <= r_bias;
        end
    end

    // ------------------------------------------------------------ assertions
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input accepted while sequencer busy");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_RUN && !r_div_zero && !r_div_ovf) |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    a_div_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_DONE) |->
            ($past(r_state) == ST_DIV_RUN && $past(r_dcnt) == 5'd31))
        else $error("gain taken before all quotient bits");

    a_result_from_out_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result register loaded outside the output step");

endmodule
